FILE: rtl/bez_pkg.sv
// ---------------------------------------------------------------------------
// bez_pkg: shared constants for the cubic bezier tessellator
// Default widths, segment count limits, queue depth and the width of the
// curve request word that passes from the front part to the back part.
// ---------------------------------------------------------------------------
package bez_pkg;

  // default configuration
  localparam int unsigned COORD_BITS_DEF      = 24;
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_SEGMENTS_DEF    = 63;

  // segment count and point index width
  localparam int unsigned SEG_BITS     = 6;
  localparam int unsigned MIN_SEGMENTS = 2;

  // curve requests held between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // four points of two coordinates, count, step quotient, step remainder
  function automatic int unsigned bez_job_bits(int unsigned coord_bits,
                                               int unsigned frac_bits);
    return 8 * coord_bits + 2 * SEG_BITS + frac_bits + 1;
  endfunction

endpackage

FILE: rtl/bez_if.sv
// ---------------------------------------------------------------------------
// bez_if: handshake channels of the cubic bezier tessellator
// Curve request channel (four control points and a segment count) and
// point result channel (one curve point per transfer).
// ---------------------------------------------------------------------------
interface bez_curve_if
  import bez_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] ctrl1_x;
  logic signed [COORD_BITS-1:0] ctrl1_y;
  logic signed [COORD_BITS-1:0] ctrl2_x;
  logic signed [COORD_BITS-1:0] ctrl2_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [SEG_BITS-1:0]          segments;

  modport source (
    output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           end_x, end_y, segments,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
           end_x, end_y, segments,
    output ready
  );
endinterface

interface bez_point_if
  import bez_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [SEG_BITS-1:0]          point_index;
  logic                         last;

  modport source (
    output valid, point_x, point_y, point_index, last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_index, last,
    output ready
  );
endinterface

FILE: rtl/bez_front.sv
// ---------------------------------------------------------------------------
// bez_front: curve request intake
// Takes a curve request, clamps the segment count and works out the
// parameter step 2^F / n as quotient and remainder with a bit-serial
// restoring divider, then hands the request on to the queue.
// ---------------------------------------------------------------------------
module bez_front
  import bez_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
  localparam int unsigned JOB_W          = bez_job_bits(COORD_BITS, PARAM_FRAC_BITS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bez_curve_if.sink        curve_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output logic [JOB_W-1:0] job_o
);

  localparam int unsigned STEPS = PARAM_FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);
  localparam logic [PARAM_FRAC_BITS:0] DVD_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } front_state_e;

  typedef struct packed {
    logic [3:0][COORD_BITS-1:0] px;
    logic [3:0][COORD_BITS-1:0] py;
    logic [SEG_BITS-1:0]        n;
    logic [PARAM_FRAC_BITS:0]   q;
    logic [SEG_BITS-1:0]        r;
  } job_t;

  front_state_e               state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [3:0][COORD_BITS-1:0] px_q, py_q;
  logic [SEG_BITS-1:0]        n_q;
  logic [SEG_BITS-1:0]        seg_clamped;
  logic [PARAM_FRAC_BITS:0]   dvd_q, dvd_d;
  logic [SEG_BITS-1:0]        rem_q, rem_d;
  logic [SEG_BITS:0]          rem_sh;
  logic                       fits;
  logic                       accept;
  job_t                       job;

  assign curve_i.ready = (state_q == FS_IDLE);
  assign accept        = curve_i.valid && curve_i.ready;

  // segment count limits
  always_comb begin
    priority if (curve_i.segments < SEG_BITS'(MIN_SEGMENTS)) begin
      seg_clamped = SEG_BITS'(MIN_SEGMENTS);
    end else if (curve_i.segments > SEG_BITS'(MAX_SEGMENTS)) begin
      seg_clamped = SEG_BITS'(MAX_SEGMENTS);
    end else begin
      seg_clamped = curve_i.segments;
    end
  end

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    rem_sh = {rem_q, dvd_q[PARAM_FRAC_BITS]};
    fits   = (rem_sh >= {1'b0, n_q});
    rem_d  = fits ? SEG_BITS'(rem_sh - {1'b0, n_q}) : rem_sh[SEG_BITS-1:0];
    dvd_d  = {dvd_q[PARAM_FRAC_BITS-1:0], fits};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          state_d = FS_DIV;
          cnt_d   = CNT_W'(STEPS);
        end
      end
      FS_DIV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (job_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // request capture and divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q[0] <= curve_i.start_x;
      py_q[0] <= curve_i.start_y;
      px_q[1] <= curve_i.ctrl1_x;
      py_q[1] <= curve_i.ctrl1_y;
      px_q[2] <= curve_i.ctrl2_x;
      py_q[2] <= curve_i.ctrl2_y;
      px_q[3] <= curve_i.end_x;
      py_q[3] <= curve_i.end_y;
      n_q     <= seg_clamped;
      rem_q   <= '0;
      dvd_q   <= DVD_ONE;
    end else if (state_q == FS_DIV) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  // outgoing request
  always_comb begin
    job.px = px_q;
    job.py = py_q;
    job.n  = n_q;
    job.q  = dvd_q;
    job.r  = rem_q;
  end

  assign job_o       = job;
  assign job_valid_o = (state_q == FS_PUSH);

endmodule

FILE: rtl/bez_fifo.sv
// ---------------------------------------------------------------------------
// bez_fifo: short request queue
// Register-based first-in first-out queue that decouples the intake from
// the point generator.
// ---------------------------------------------------------------------------
module bez_fifo
  import bez_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNT_W'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

FILE: rtl/bez_back.sv
// ---------------------------------------------------------------------------
// bez_back: point generator and blending pipeline
// Steps the curve parameter one sample per cycle and evaluates the
// Bernstein blend exactly in a six-stage pipeline; generator and pipeline
// stall as a whole when the output register is held.
// ---------------------------------------------------------------------------
module bez_back
  import bez_pkg::*;
#(
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
  localparam int unsigned JOB_W          = bez_job_bits(COORD_BITS, PARAM_FRAC_BITS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  logic [JOB_W-1:0] job_i,
  bez_point_if.source      point_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned F      = PARAM_FRAC_BITS;
  localparam int unsigned TW     = F + 1;
  localparam int unsigned SQ_W   = 2 * F + 1;
  localparam int unsigned WW     = 3 * F + 1;
  localparam int unsigned LO_W   = (WW + 1) / 2;
  localparam int unsigned HI_W   = WW - LO_W;
  localparam int unsigned PLO_W  = LO_W + C;
  localparam int unsigned PHI_W  = HI_W + C;
  localparam int unsigned SLO_W  = PLO_W + 2;
  localparam int unsigned SHI_W  = PHI_W + 2;
  localparam int unsigned ACC_W  = WW + C + 2;
  localparam int unsigned SHIFT  = 3 * F;
  localparam logic [C-1:0]     FLIP   = {1'b1, {(C - 1){1'b0}}};
  localparam logic [TW-1:0]    T_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [ACC_W-1:0] ROUND  = ACC_W'(1) << (SHIFT - 1);

  typedef struct packed {
    logic [3:0][C-1:0]   px;
    logic [3:0][C-1:0]   py;
    logic [SEG_BITS-1:0] n;
    logic [TW-1:0]       q;
    logic [SEG_BITS-1:0] r;
  } job_t;

  job_t job_in;

  // generator state
  logic                active_q;
  logic [3:0][C-1:0]   cur_px_q, cur_py_q;
  logic [SEG_BITS-1:0] n_q, r_q, i_q, frac_q, frac_next;
  logic [TW-1:0]       q_q, t_q, t_next;
  logic [SEG_BITS:0]   frac_sum;
  logic                wrap, gen_last, gen_fire, adv, load;

  // pipeline registers
  logic                   v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic [TW-1:0]          t1_q, u1_q, t2_q, u2_q;
  logic [SQ_W-1:0]        uu2_q, tt2_q, ut2_q;
  logic [3:0][WW-1:0]     w3_q;
  logic [3:0][C-1:0]      px1_q, py1_q, px2_q, py2_q, px3_q, py3_q;
  logic [3:0][PLO_W-1:0]  plo_x4_q, plo_y4_q;
  logic [3:0][PHI_W-1:0]  phi_x4_q, phi_y4_q;
  logic [SLO_W-1:0]       slo_x5_q, slo_y5_q;
  logic [SHI_W-1:0]       shi_x5_q, shi_y5_q;
  logic [SEG_BITS-1:0]    idx1_q, idx2_q, idx3_q, idx4_q, idx5_q, out_idx_q;
  logic                   last1_q, last2_q, last3_q, last4_q, last5_q, out_last_q;
  logic [C-1:0]           out_x_q, out_y_q;

  // stage combinational values
  logic [2*TW-1:0]        uu_full, tt_full, ut_full;
  logic [SQ_W+TW-1:0]     m0, m1, m2, m3, m1x3, m2x3;
  logic [ACC_W-1:0]       acc_x, acc_y;

  assign job_in = job_i;

  // whole pipeline moves unless a finished point is held at the output
  assign adv         = !out_valid_q || point_o.ready;
  assign gen_last    = (i_q == n_q);
  assign gen_fire    = active_q && adv;
  assign job_ready_o = !active_q || (gen_fire && gen_last);
  assign load        = job_valid_i && job_ready_o;

  // next sample parameter: t += q, plus one when the remainder wraps
  always_comb begin
    frac_sum  = {1'b0, frac_q} + {1'b0, r_q};
    wrap      = (frac_sum >= {1'b0, n_q});
    frac_next = wrap ? SEG_BITS'(frac_sum - {1'b0, n_q}) : frac_sum[SEG_BITS-1:0];
    t_next    = t_q + q_q + TW'(wrap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (job_ready_o) begin
      active_q <= job_valid_i;
    end
  end

  // curve registers, stored in offset binary
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        cur_px_q[k] <= job_in.px[k] ^ FLIP;
        cur_py_q[k] <= job_in.py[k] ^ FLIP;
      end
      n_q    <= job_in.n;
      q_q    <= job_in.q;
      r_q    <= job_in.r;
      i_q    <= '0;
      t_q    <= '0;
      frac_q <= '0;
    end else if (gen_fire) begin
      i_q    <= i_q + SEG_BITS'(1);
      t_q    <= t_next;
      frac_q <= frac_next;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= active_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // products of the parameter pair
  always_comb begin
    uu_full = u1_q * u1_q;
    tt_full = t1_q * t1_q;
    ut_full = u1_q * t1_q;
  end

  // cubic weights
  always_comb begin
    m0   = uu2_q * u2_q;
    m1   = uu2_q * t2_q;
    m2   = ut2_q * t2_q;
    m3   = tt2_q * t2_q;
    m1x3 = m1 + (m1 << 1);
    m2x3 = m2 + (m2 << 1);
  end

  // final weighted sums with rounding
  always_comb begin
    acc_x = {shi_x5_q, {LO_W{1'b0}}} + {{HI_W{1'b0}}, slo_x5_q} + ROUND;
    acc_y = {shi_y5_q, {LO_W{1'b0}}} + {{HI_W{1'b0}}, slo_y5_q} + ROUND;
  end

  // pipeline datapath
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: sample parameter
      t1_q    <= t_q;
      u1_q    <= T_ONE - t_q;
      idx1_q  <= i_q;
      last1_q <= gen_last;
      px1_q   <= cur_px_q;
      py1_q   <= cur_py_q;
      // stage 2: squares and cross product
      uu2_q   <= uu_full[SQ_W-1:0];
      tt2_q   <= tt_full[SQ_W-1:0];
      ut2_q   <= ut_full[SQ_W-1:0];
      u2_q    <= u1_q;
      t2_q    <= t1_q;
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      // stage 3: bernstein weights
      w3_q[0] <= m0[WW-1:0];
      w3_q[1] <= m1x3[WW-1:0];
      w3_q[2] <= m2x3[WW-1:0];
      w3_q[3] <= m3[WW-1:0];
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
      px3_q   <= px2_q;
      py3_q   <= py2_q;
      // stage 4: split weight times coordinate
      for (int k = 0; k < 4; k++) begin
        plo_x4_q[k] <= w3_q[k][LO_W-1:0] * px3_q[k];
        plo_y4_q[k] <= w3_q[k][LO_W-1:0] * py3_q[k];
        phi_x4_q[k] <= w3_q[k][WW-1:LO_W] * px3_q[k];
        phi_y4_q[k] <= w3_q[k][WW-1:LO_W] * py3_q[k];
      end
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
      // stage 5: sum the four control point terms
      slo_x5_q <= {2'b00, plo_x4_q[0]} + {2'b00, plo_x4_q[1]}
                + {2'b00, plo_x4_q[2]} + {2'b00, plo_x4_q[3]};
      slo_y5_q <= {2'b00, plo_y4_q[0]} + {2'b00, plo_y4_q[1]}
                + {2'b00, plo_y4_q[2]} + {2'b00, plo_y4_q[3]};
      shi_x5_q <= {2'b00, phi_x4_q[0]} + {2'b00, phi_x4_q[1]}
                + {2'b00, phi_x4_q[2]} + {2'b00, phi_x4_q[3]};
      shi_y5_q <= {2'b00, phi_y4_q[0]} + {2'b00, phi_y4_q[1]}
                + {2'b00, phi_y4_q[2]} + {2'b00, phi_y4_q[3]};
      idx5_q  <= idx4_q;
      last5_q <= last4_q;
      // output register, back to two's complement
      out_x_q    <= acc_x[SHIFT +: C] ^ FLIP;
      out_y_q    <= acc_y[SHIFT +: C] ^ FLIP;
      out_idx_q  <= idx5_q;
      out_last_q <= last5_q;
    end
  end

  assign point_o.valid       = out_valid_q;
  assign point_o.point_x     = out_x_q;
  assign point_o.point_y     = out_y_q;
  assign point_o.point_index = out_idx_q;
  assign point_o.last        = out_last_q;

endmodule

FILE: rtl/cubic_bezier_tessellator.sv
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator: cubic bezier curve to point list
// Each curve request carries four control points and a segment count n
// (0 and 1 count as 2, counts above MAX_SEGMENTS are clipped). The block
// returns n+1 points on the point channel, index 0 to n, last flagged on
// the final one; each coordinate is the exact blend rounded half up.
//
// curve_i: request channel, taken when valid and ready are high together.
// point_o: result channel, one point per cycle while the receiver is ready.
// The intake works out the step of each curve in its bit-serial step
// divider and takes no new request until it has handed the current one
// on to the queue; the point generator steps through the points of each
// curve in turn. Two curve requests queue between intake and generator.
// A stalled receiver holds the output register and freezes the point
// pipeline; the intake keeps taking requests until the queue is full.
// Reset clears all control state and leaves both channels idle.
// ---------------------------------------------------------------------------
module cubic_bezier_tessellator
  import bez_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bez_curve_if.sink   curve_i,
  bez_point_if.source point_o
);

  localparam int unsigned JOB_W = bez_job_bits(COORD_BITS, PARAM_FRAC_BITS);

  logic             front_valid, front_ready;
  logic [JOB_W-1:0] front_job;
  logic             back_valid, back_ready;
  logic [JOB_W-1:0] back_job;

  // intake and step divider
  bez_front #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .curve_i     (curve_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  // request queue
  bez_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_job),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_job)
  );

  // point generator and blend pipeline
  bez_back #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .point_o     (point_o)
  );

  // intake is busy dividing right after a request
  ap_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    curve_i.valid && curve_i.ready |=> !curve_i.ready)
    else $error("intake ready straight after a request");

  // points of one curve follow without gaps and count up
  ap_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && point_o.ready && !point_o.last
    |=> point_o.valid && point_o.point_index == $past(point_o.point_index) + SEG_BITS'(1))
    else $error("point sequence broken within a curve");

  // a new curve starts at index zero
  ap_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && point_o.ready && point_o.last
    |=> !point_o.valid || point_o.point_index == '0)
    else $error("curve does not start at index zero");

  // final index lies within the clamped segment range
  ap_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && point_o.last
    |-> point_o.point_index >= SEG_BITS'(MIN_SEGMENTS)
        && point_o.point_index <= SEG_BITS'(MAX_SEGMENTS))
    else $error("final point index outside segment range");

endmodule

FILE: verif/tb_cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cubic_bezier_tessellator: self-checking bench for the bezier tessellator
// Sends curve requests with extreme, small-count and random control points,
// predicts every curve point with exact wide arithmetic and compares each
// returned point field by field, under random sender gaps and receiver
// stalls.
// ---------------------------------------------------------------------------
module tb_cubic_bezier_tessellator
  import bez_pkg::*;
();

  localparam int CB       = COORD_BITS_DEF;
  localparam int FB       = PARAM_FRAC_BITS_DEF;
  localparam int ACC_BITS = 3 * FB + CB + 4;
  localparam int TAIL_CYCLES = 64;
  localparam longint TIMEOUT_NS = 4_000_000;

  typedef logic signed [CB-1:0] coord_t;
  localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};

  typedef struct {
    coord_t              x[4];
    coord_t              y[4];
    logic [SEG_BITS-1:0] segments;
  } curve_t;

  typedef struct {
    coord_t              x;
    coord_t              y;
    logic [SEG_BITS-1:0] index;
    logic                last;
  } point_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bez_curve_if curve_if ();
  bez_point_if point_if ();

  cubic_bezier_tessellator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .curve_i (curve_if),
    .point_o (point_if)
  );

  point_t      expected_points[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps_on = 1'b0;
  logic [15:0] ready_mask = 16'hffff;
  logic [3:0]  stall_phase = 4'd0;

  // clock
  always #1 clk_i = ~clk_i;

  // exact blend of one coordinate, rounded half up
  function automatic coord_t blend_coord(input coord_t p0, input coord_t p1,
                                         input coord_t p2, input coord_t p3,
                                         input logic [FB:0] t);
    logic [ACC_BITS-1:0] u_w, t_w, acc;
    logic [ACC_BITS-1:0] o0, o1, o2, o3;
    logic [CB-1:0]       r;
    // offset binary so every term stays non-negative
    o0 = ACC_BITS'({~p0[CB-1], p0[CB-2:0]});
    o1 = ACC_BITS'({~p1[CB-1], p1[CB-2:0]});
    o2 = ACC_BITS'({~p2[CB-1], p2[CB-2:0]});
    o3 = ACC_BITS'({~p3[CB-1], p3[CB-2:0]});
    t_w = ACC_BITS'(t);
    u_w = (ACC_BITS'(1) << FB) - t_w;
    acc = u_w * u_w * u_w * o0 + 3 * u_w * u_w * t_w * o1
        + 3 * u_w * t_w * t_w * o2 + t_w * t_w * t_w * o3;
    acc = acc + (ACC_BITS'(1) << (3 * FB - 1));
    r = acc[3 * FB +: CB];
    return {~r[CB-1], r[CB-2:0]};
  endfunction

  // all points of one curve request, in order
  function automatic void predict_curve_points(input curve_t c);
    int unsigned n;
    logic [FB:0] t;
    point_t      pt;
    n = c.segments;
    if (n < MIN_SEGMENTS) n = MIN_SEGMENTS;
    if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
    for (int unsigned i = 0; i <= n; i++) begin
      t = (FB + 1)'((i << FB) / n);
      pt.x = blend_coord(c.x[0], c.x[1], c.x[2], c.x[3], t);
      pt.y = blend_coord(c.y[0], c.y[1], c.y[2], c.y[3], t);
      pt.index = SEG_BITS'(i);
      pt.last = (i == n);
      expected_points.insert(expected_points.size(), pt);
    end
  endfunction

  function automatic curve_t make_curve(input coord_t x0, input coord_t y0,
                                        input coord_t x1, input coord_t y1,
                                        input coord_t x2, input coord_t y2,
                                        input coord_t x3, input coord_t y3,
                                        input logic [SEG_BITS-1:0] seg);
    curve_t c;
    c.x[0] = x0; c.y[0] = y0; c.x[1] = x1; c.y[1] = y1;
    c.x[2] = x2; c.y[2] = y2; c.x[3] = x3; c.y[3] = y3;
    c.segments = seg;
    return c;
  endfunction

  // mostly full-range values, some extremes and some near zero
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'($urandom_range(0, 1023)) - coord_t'(512);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [SEG_BITS-1:0] pick_segments();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return SEG_BITS'(1);
        2: return SEG_BITS'(2);
        default: return '1;
      endcase
    end
    return SEG_BITS'($urandom_range(0, (1 << SEG_BITS) - 1));
  endfunction

  function automatic curve_t random_curve(input logic [SEG_BITS-1:0] seg);
    curve_t c;
    for (int k = 0; k < 4; k++) begin
      c.x[k] = pick_coord();
      c.y[k] = pick_coord();
    end
    c.segments = seg;
    return c;
  endfunction

  function automatic logic [15:0] pick_ready_mask(input stall_mode_e mode);
    case (mode)
      STALL_HEAVY:  return ($urandom_range(0, 1) == 0) ? 16'h0001 : 16'h0101;
      STALL_RANDOM: return ($urandom_range(0, 3) == 0) ? 16'hffff :
                           (16'($urandom()) | 16'h0001);
      default:      return 16'hffff;
    endcase
  endfunction

  // one curve request; called just after a rising edge
  task automatic send_curve(input curve_t c);
    int unsigned gap;
    if (sender_gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 6);
      curve_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    curve_if.valid    <= 1'b1;
    curve_if.start_x  <= c.x[0];
    curve_if.start_y  <= c.y[0];
    curve_if.ctrl1_x  <= c.x[1];
    curve_if.ctrl1_y  <= c.y[1];
    curve_if.ctrl2_x  <= c.x[2];
    curve_if.ctrl2_y  <= c.y[2];
    curve_if.end_x    <= c.x[3];
    curve_if.end_y    <= c.y[3];
    curve_if.segments <= c.segments;
    @(posedge clk_i);
    while (!curve_if.ready) @(posedge clk_i);
    predict_curve_points(c);
  endtask

  // extreme control points and curve ends
  task automatic test_extreme_points();
    send_curve(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 4));
    send_curve(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 4));
    send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                          COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, '1));
    send_curve(make_curve(COORD_MAX, COORD_MIN, '0, '0, '0, '0,
                          COORD_MIN, COORD_MAX, 10));
    send_curve(make_curve('0, '0, '0, '0, '0, '0, '0, '0, 8));
    send_curve(make_curve('1, '1, '1, '1, '1, '1, '1, '1, 5));
    send_curve(make_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32));
    send_curve(random_curve('1));
  endtask

  // small counts raised to the minimum, and the largest counts
  task automatic test_segment_counts();
    curve_t c;
    c = random_curve('0);
    foreach (c.x[k]) c.x[k] = coord_t'($urandom());
    foreach (c.y[k]) c.y[k] = coord_t'($urandom());
    for (int s = 0; s < 4; s++) begin
      c.segments = SEG_BITS'(s);
      send_curve(c);
    end
    c.segments = SEG_BITS'((1 << SEG_BITS) - 2);
    send_curve(c);
    c.segments = '1;
    send_curve(c);
  endtask

  // random curves under a given idling pattern
  task automatic test_random_curves(input int unsigned count, input bit gaps_on,
                                    input stall_mode_e mode);
    sender_gaps_on = gaps_on;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0) ready_mask <= pick_ready_mask(mode);
      send_curve(random_curve(pick_segments()));
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      point_if.ready <= 1'b0;
    end else begin
      point_if.ready <= ready_mask[stall_phase];
    end
    stall_phase <= stall_phase + 4'd1;
  end

  // compare each returned point with the oldest expectation
  always @(posedge clk_i) begin : point_checker
    point_t want;
    if (rst_ni && point_if.valid && point_if.ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected point: x=%0d y=%0d index=%0d last=%0b",
                   point_if.point_x, point_if.point_y, point_if.point_index,
                   point_if.last);
      end else begin
        want = expected_points.pop_front();
        if (point_if.point_x !== want.x || point_if.point_y !== want.y ||
            point_if.point_index !== want.index || point_if.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point mismatch: expected x=%0d y=%0d index=%0d last=%0b,",
                     want.x, want.y, want.index, want.last,
                     " got x=%0d y=%0d index=%0d last=%0b",
                     point_if.point_x, point_if.point_y, point_if.point_index,
                     point_if.last);
        end
      end
    end
  end

  // main sequence
  initial begin
    curve_if.valid    = 1'b0;
    curve_if.start_x  = '0;
    curve_if.start_y  = '0;
    curve_if.ctrl1_x  = '0;
    curve_if.ctrl1_y  = '0;
    curve_if.ctrl2_x  = '0;
    curve_if.ctrl2_y  = '0;
    curve_if.end_x    = '0;
    curve_if.end_y    = '0;
    curve_if.segments = '0;
    point_if.ready    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_points();
    test_segment_counts();
    test_random_curves(110, 1'b1, STALL_RANDOM);
    test_random_curves(110, 1'b0, STALL_NONE);
    test_random_curves(110, 1'b1, STALL_HEAVY);
    test_random_curves(120, 1'b0, STALL_RANDOM);

    curve_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
